[hdl/erc_pkg.sv]
package erc_pkg;

  localparam int SENSOR_WIDTH  = 1280;
  localparam int SENSOR_HEIGHT = 720;
  localparam int TIME_BITS     = 32;

  localparam int X_W      = 11;
  localparam int Y_W      = 10;
  localparam int EVT_T_W  = 32;

  localparam int BORDER_MARGIN = 4;
  localparam int SURFACE_DEPTH = SENSOR_WIDTH * SENSOR_HEIGHT;
  localparam int ADDR_W        = $clog2(SURFACE_DEPTH);
  localparam int DELTA_W       = ADDR_W + 1;

  localparam int RING3_N  = 16;
  localparam int RING4_N  = 20;
  localparam int ARC3_MIN = 3;
  localparam int ARC3_MAX = 6;
  localparam int ARC4_MIN = 4;
  localparam int ARC4_MAX = 8;

  // counts 0..RING4_N, also wide enough for an arc length or a popcount
  localparam int CNT_W = $clog2(RING4_N + 1);
  localparam int R3_IDX_W = $clog2(RING3_N);

  // ring points as (row offset, column offset)
  localparam int R3_DR [RING3_N] = '{0, 1, 2, 3, 3, 3, 2, 1, 0, -1, -2, -3, -3, -3, -2, -1};
  localparam int R3_DC [RING3_N] = '{3, 3, 2, 1, 0, -1, -2, -3, -3, -3, -2, -1, 0, 1, 2, 3};
  localparam int R4_DR [RING4_N] = '{0, 1, 2, 3, 4, 4, 4, 3, 2, 1,
                                     0, -1, -2, -3, -4, -4, -4, -3, -2, -1};
  localparam int R4_DC [RING4_N] = '{4, 4, 3, 2, 1, 0, -1, -2, -3, -4,
                                     -4, -4, -3, -2, -1, 0, 1, 2, 3, 4};

  typedef struct packed {
    logic load;   // shift a fetched word into the ring
    logic scan;   // test the head as threshold, then rotate
    logic ring4;  // outer ring selected
  } arc_ctrl_t;

  // linear surface offset of ring point idx
  function automatic logic signed [DELTA_W-1:0] ring_delta(input logic r4,
                                                           input logic [CNT_W-1:0] idx);
    int d;
    if (r4) begin
      d = R4_DR[idx] * SENSOR_WIDTH + R4_DC[idx];
    end else begin
      d = R3_DR[idx[R3_IDX_W-1:0]] * SENSOR_WIDTH + R3_DC[idx[R3_IDX_W-1:0]];
    end
    return DELTA_W'(d);
  endfunction

endpackage

[hdl/erc_arc_unit.sv]
module erc_arc_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  erc_pkg::arc_ctrl_t             ctrl,
  input  logic [erc_pkg::TIME_BITS-1:0]  load_data,
  output logic                           pass
);
  import erc_pkg::*;

  logic [TIME_BITS-1:0] ring [RING4_N];
  logic [TIME_BITS-1:0] shift_in;
  logic [RING4_N-1:0]   mask;
  logic [RING4_N-1:0]   rise;
  logic [CNT_W-1:0]     ones;
  logic [CNT_W-1:0]     rises;
  logic [CNT_W-1:0]     len_lo;
  logic [CNT_W-1:0]     len_hi;
  logic                 arc_ok;
  logic                 hit;

  assign shift_in = ctrl.scan ? ring[0] : load_data;
  assign len_lo   = ctrl.ring4 ? CNT_W'(ARC4_MIN) : CNT_W'(ARC3_MIN);
  assign len_hi   = ctrl.ring4 ? CNT_W'(ARC4_MAX) : CNT_W'(ARC3_MAX);

  // The head of the ring is the threshold: the points at or above it must form
  // one contiguous arc of legal length. Rotation keeps both checks unchanged.
  always_comb begin
    for (int k = 0; k < RING4_N; k++) begin
      mask[k] = ((k < RING3_N) || ctrl.ring4) && (ring[k] >= ring[0]);
    end
    rise[0] = mask[0] & ~(ctrl.ring4 ? mask[RING4_N-1] : mask[RING3_N-1]);
    for (int k = 1; k < RING4_N; k++) begin
      rise[k] = mask[k] & ~mask[k-1];
    end
    ones  = '0;
    rises = '0;
    for (int k = 0; k < RING4_N; k++) begin
      ones  = ones + CNT_W'(mask[k]);
      rises = rises + CNT_W'(rise[k]);
    end
    arc_ok = (rises == CNT_W'(1)) && (ones >= len_lo) && (ones <= len_hi);
  end

  always_ff @(posedge clk) begin
    if (ctrl.load || ctrl.scan) begin
      for (int k = 0; k < RING4_N - 1; k++) begin
        ring[k] <= ring[k+1];
      end
      ring[RING3_N-1] <= ctrl.ring4 ? ring[RING3_N] : shift_in;
      ring[RING4_N-1] <= shift_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit <= 1'b0;
    end else if (ctrl.load) begin
      hit <= 1'b0;
    end else if (ctrl.scan) begin
      hit <= hit | arc_ok;
    end
  end

  assign pass = hit;

endmodule

[hdl/event_ring_corner_detector.sv]
// An accepted word passes the address and write steps and, for an interior word
// with detection enabled, an inner ring fetch and scan; if that ring passes, the
// outer ring is fetched and scanned too. No new word is taken until its result is
// loaded to the output. Each ring point is one read of the surface memory's read
// port, and each ring is scanned one threshold a cycle. Reset: synchronous; clears
// all SENSOR_WIDTH*SENSOR_HEIGHT (921600) surface entries, one a cycle, in_stall high.
module event_ring_corner_detector (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [erc_pkg::X_W-1:0]      event_x,
  input  logic [erc_pkg::Y_W-1:0]      event_y,
  input  logic [erc_pkg::EVT_T_W-1:0]  event_time,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [erc_pkg::X_W-1:0]      corner_x,
  output logic [erc_pkg::Y_W-1:0]      corner_y,
  output logic                         is_corner
);
  import erc_pkg::*;

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_ADDR   = 3'd2;
  localparam logic [2:0] ST_WRITE  = 3'd3;
  localparam logic [2:0] ST_GATHER = 3'd4;
  localparam logic [2:0] ST_SCAN   = 3'd5;
  localparam logic [2:0] ST_DECIDE = 3'd6;
  localparam logic [2:0] ST_FINISH = 3'd7;

  localparam logic REG_DETECT = 1'b0;

  localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(SURFACE_DEPTH - 1);

  logic [2:0]           state;
  logic                 detect_enable;
  logic                 cfg_write;
  logic                 accept;
  logic                 ev_in_range;
  logic                 ev_interior;
  logic [X_W-1:0]       x_q;
  logic [Y_W-1:0]       y_q;
  logic [TIME_BITS-1:0] t_q;
  logic                 in_range_q;
  logic                 interior_q;
  logic [ADDR_W-1:0]    center_addr;
  logic [ADDR_W-1:0]    clr_addr;
  logic [CNT_W-1:0]     cnt;
  logic [CNT_W-1:0]     ring_n;
  logic                 ring4;
  logic                 corner_q;
  logic                 out_load;
  logic                 mem_we;
  logic [ADDR_W-1:0]    wr_addr;
  logic [ADDR_W-1:0]    rd_addr;
  logic [TIME_BITS-1:0] wr_data;
  logic [TIME_BITS-1:0] rd_data;
  logic [TIME_BITS-1:0] surface [SURFACE_DEPTH];
  arc_ctrl_t            arc_ctrl;
  logic                 arc_pass;

  // configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == REG_DETECT) ? {31'b0, detect_enable} : 32'b0;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  assign ev_in_range = (32'(event_x) < SENSOR_WIDTH) && (32'(event_y) < SENSOR_HEIGHT);
  assign ev_interior = ev_in_range &&
                       (32'(event_x) >= BORDER_MARGIN) &&
                       (32'(event_x) < SENSOR_WIDTH - BORDER_MARGIN) &&
                       (32'(event_y) >= BORDER_MARGIN) &&
                       (32'(event_y) < SENSOR_HEIGHT - BORDER_MARGIN);

  assign ring_n   = ring4 ? CNT_W'(RING4_N) : CNT_W'(RING3_N);
  assign out_load = (state == ST_FINISH) && (!out_valid || !out_stall);

  // surface memory: one write port, one registered read port
  assign mem_we  = (state == ST_CLEAR) || ((state == ST_WRITE) && in_range_q);
  assign wr_addr = (state == ST_CLEAR) ? clr_addr : center_addr;
  assign wr_data = (state == ST_CLEAR) ? '0 : t_q;
  assign rd_addr = ADDR_W'(DELTA_W'(center_addr) + unsigned'(ring_delta(ring4, cnt)));

  always_ff @(posedge clk) begin
    if (mem_we) begin
      surface[wr_addr] <= wr_data;
    end
    rd_data <= surface[rd_addr];
  end

  // read data arrives the cycle after its address, so shift in from the second step
  assign arc_ctrl.load  = (state == ST_GATHER) && (cnt != '0);
  assign arc_ctrl.scan  = (state == ST_SCAN);
  assign arc_ctrl.ring4 = ring4;

  erc_arc_unit u_arc (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (arc_ctrl),
    .load_data (rd_data),
    .pass      (arc_pass)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      detect_enable <= 1'b1;
      clr_addr      <= '0;
      cnt           <= '0;
      ring4         <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_write && (paddr[2] == REG_DETECT)) begin
        detect_enable <= pwdata[0];
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + ADDR_W'(1);
          if (clr_addr == CLR_LAST) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            state <= ST_ADDR;
          end
        end
        ST_ADDR: begin
          state <= ST_WRITE;
        end
        ST_WRITE: begin
          cnt   <= '0;
          ring4 <= 1'b0;
          state <= (detect_enable && interior_q) ? ST_GATHER : ST_FINISH;
        end
        ST_GATHER: begin
          if (cnt == ring_n) begin
            cnt   <= '0;
            state <= ST_SCAN;
          end else begin
            cnt <= cnt + CNT_W'(1);
          end
        end
        ST_SCAN: begin
          if (cnt == ring_n - CNT_W'(1)) begin
            cnt   <= '0;
            state <= ST_DECIDE;
          end else begin
            cnt <= cnt + CNT_W'(1);
          end
        end
        ST_DECIDE: begin
          // inner ring passed: go fetch the outer ring
          if (!ring4 && arc_pass) begin
            ring4 <= 1'b1;
            state <= ST_GATHER;
          end else begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x_q        <= event_x;
      y_q        <= event_y;
      t_q        <= event_time[TIME_BITS-1:0];
      in_range_q <= ev_in_range;
      interior_q <= ev_interior;
    end
    if (state == ST_ADDR) begin
      center_addr <= ADDR_W'(ADDR_W'(y_q) * ADDR_W'(SENSOR_WIDTH) + ADDR_W'(x_q));
    end
    if (state == ST_WRITE) begin
      corner_q <= 1'b0;
    end else if (state == ST_DECIDE) begin
      corner_q <= ring4 && arc_pass;
    end
    if (out_load) begin
      corner_x  <= x_q;
      corner_y  <= y_q;
      is_corner <= corner_q;
    end
  end

  a_accept_blocks: assert property (@(posedge clk) disable iff (rst)
    accept |=> in_stall)
    else $error("word accepted while previous word still in progress");

  a_gather_interior: assert property (@(posedge clk) disable iff (rst)
    (state == ST_GATHER) |-> (interior_q && detect_enable))
    else $error("ring fetch started for a border or disabled word");

  a_out_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ST_FINISH))
    else $error("result presented outside finish step");

  a_outer_after_inner: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_DECIDE) && !ring4 && arc_pass) |=> (ring4 && (state == ST_GATHER)))
    else $error("outer ring not fetched after inner ring pass");

endmodule
